// ===== rtl/rbb_pkg.sv =====
// Shared constants and types of the byte stream register bridge.
// No dependencies; the queue, parser, executor, top level and testbench import it.
package rbb_pkg;

  localparam int REG_COUNT = 256;
  localparam int ADDR_W = 15;
  localparam int DATA_W = 32;
  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // command parser phases
  localparam logic [2:0] PH_ADDR_HI = 3'd0;
  localparam logic [2:0] PH_ADDR_LO = 3'd1;
  localparam logic [2:0] PH_DATA0   = 3'd2;
  localparam logic [2:0] PH_DATA1   = 3'd3;
  localparam logic [2:0] PH_DATA2   = 3'd4;
  localparam logic [2:0] PH_DATA3   = 3'd5;

  typedef struct packed {
    logic              is_read;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } rbb_cmd_t;

endpackage

// ===== rtl/rbb_ifs.sv =====
// Valid/ready channel interfaces for received and transmitted words.
// No dependencies.
interface rbb_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rbb_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

// ===== rtl/rbb_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module rbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/rbb_cmd_fifo.sv =====
// Short command queue between the parser and the register executor.
// Depends on rbb_pkg.
module rbb_cmd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rbb_pkg::rbb_cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output rbb_pkg::rbb_cmd_t head_cmd
);
  import rbb_pkg::*;

  rbb_cmd_t            slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign full       = (count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rbb_front.sv =====
// Command parser: takes one received word per cycle, unless the queue is full on a
// command-ending word, and emits read and write commands. Depends on rbb_pkg and rbb_ifs.
module rbb_front (
  input  logic              clk,
  input  logic              rst,
  rbb_rx_if.sink            rx,
  output logic              push,
  output rbb_pkg::rbb_cmd_t push_cmd,
  input  logic              full
);
  import rbb_pkg::*;

  logic [2:0]        phase;
  logic [2:0]        phase_next;
  logic [ADDR_W-1:0] addr_hold;
  logic              read_flag;
  logic [23:0]       data_gather;
  logic              needs_push;
  logic              take;

  always_comb begin
    needs_push = 1'b0;
    phase_next = PH_ADDR_HI;
    unique case (phase)
      PH_ADDR_HI: phase_next = PH_ADDR_LO;
      PH_ADDR_LO: begin
        needs_push = read_flag;
        phase_next = read_flag ? PH_ADDR_HI : PH_DATA0;
      end
      PH_DATA0: phase_next = PH_DATA1;
      PH_DATA1: phase_next = PH_DATA2;
      PH_DATA2: phase_next = PH_DATA3;
      PH_DATA3: begin
        needs_push = 1'b1;
        phase_next = PH_ADDR_HI;
      end
      default: phase_next = PH_ADDR_LO;  // stray codes act as address high
    endcase
  end

  assign rx.ready = !(needs_push && full);
  assign take     = rx.valid && rx.ready;
  assign push     = take && needs_push;

  always_comb begin
    push_cmd.is_read = (phase == PH_ADDR_LO);
    push_cmd.addr    = (phase == PH_ADDR_LO) ? {addr_hold[ADDR_W-1:8], rx.rx_byte}
                                             : addr_hold;
    push_cmd.data    = {data_gather, rx.rx_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_ADDR_HI;
      addr_hold   <= '0;
      read_flag   <= 1'b0;
      data_gather <= '0;
    end else if (take) begin
      phase <= phase_next;
      unique case (phase)
        PH_ADDR_LO: begin
          addr_hold   <= {addr_hold[ADDR_W-1:8], rx.rx_byte};
          data_gather <= '0;
        end
        PH_DATA0, PH_DATA1, PH_DATA2: begin
          data_gather <= {data_gather[15:0], rx.rx_byte};
        end
        PH_DATA3: begin
        end
        default: begin
          read_flag <= rx.rx_byte[7];
          addr_hold <= {rx.rx_byte[6:0], 8'h00};
        end
      endcase
    end
  end

endmodule

// ===== rtl/rbb_back.sv =====
// Register executor: applies queued commands to the register store and
// streams read replies out, high word first. Depends on rbb_pkg, rbb_ifs, rbb_ram.
module rbb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  rbb_pkg::rbb_cmd_t head_cmd,
  output logic              pop,
  rbb_tx_if.source          tx
);
  import rbb_pkg::*;

  logic [REG_COUNT-1:0] written;
  logic [IDX_W-1:0]     idx;
  logic                 in_range;
  logic                 ram_we;
  logic [DATA_W-1:0]    ram_rdata;
  logic                 rd_pend;
  logic                 rd_hit;
  logic                 busy;
  logic [DATA_W-1:0]    word;
  logic [1:0]           cnt;
  logic                 tx_take;
  logic                 ser_free;

  assign idx      = head_cmd.addr[IDX_W-1:0];
  assign in_range = ({1'b0, head_cmd.addr} < (ADDR_W+1)'(REG_COUNT));

  assign tx.valid     = busy;
  assign tx.tx_byte   = word[DATA_W-1 -: 8];
  assign tx.last_byte = (cnt == 2'd3);
  assign tx_take      = tx.valid && tx.ready;

  // serializer frees up this cycle or is already idle
  assign ser_free = !rd_pend && (!busy || (tx_take && cnt == 2'd3));
  assign pop      = head_valid && (!head_cmd.is_read || ser_free);
  assign ram_we   = pop && !head_cmd.is_read && in_range;

  rbb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (idx),
    .wdata (head_cmd.data),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ram_we) begin
      written[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_hit <= in_range && written[idx];
    if (rd_pend) begin
      word <= rd_hit ? ram_rdata : '0;
    end else if (tx_take) begin
      word <= {word[DATA_W-9:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      busy    <= 1'b0;
      cnt     <= '0;
    end else begin
      rd_pend <= pop && head_cmd.is_read;
      if (rd_pend) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (tx_take) begin
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/byte_stream_register_bridge.sv =====
// Top level of the byte stream register bridge: parser, command queue, executor.
// Depends on rbb_pkg, rbb_ifs, rbb_front, rbb_cmd_fifo, rbb_back.
//
//   port  dir  payload               meaning
//   rx    in   rx_byte[7:0]          command words from the host link
//   tx    out  tx_byte[7:0], last    read reply, last flags the fourth word
//
// rx takes one word per cycle unless stalled; a write command is 6 words.
// A read reply leaves as 4 words, back to back while tx is ready, with an idle gap
// between replies for the store's registered read.
// The 4-entry command queue lets rx run while tx is stalled; rx stalls only
// on a command-ending word when the queue is full. Reset is synchronous; the
// store reads as zero after reset through per-entry written flags.
module byte_stream_register_bridge (
  input logic      clk,
  input logic      rst,
  rbb_rx_if.sink   rx,
  rbb_tx_if.source tx
);
  import rbb_pkg::*;

  logic     push;
  rbb_cmd_t push_cmd;
  logic     full;
  logic     pop;
  logic     head_valid;
  rbb_cmd_t head_cmd;

  rbb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  rbb_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  rbb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .tx         (tx)
  );

endmodule

// ===== tb/rbb_reply_checker.sv =====
// Scoreboard for the byte stream register bridge: mirrors the register store
// from the accepted rx words and checks every tx word against the predicted reply.
// Depends on rbb_pkg and the rx/tx channel interfaces in rbb_ifs.
module rbb_reply_checker (
  input  logic clk,
  input  logic rst,
  rbb_rx_if    rx,
  rbb_tx_if    tx,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rbb_pkg::*;

  typedef struct {
    logic [7:0] tx_byte;
    logic       last_byte;
  } reply_word_t;

  reply_word_t       reply_q[$];
  logic [2:0]        cmd_phase;
  logic [ADDR_W-1:0] cmd_addr;
  logic              cmd_is_read;
  logic [23:0]       data_acc;
  logic [DATA_W-1:0] reg_mirror[REG_COUNT];

  assign pending = reply_q.size();

  task automatic take_rx_word(input logic [7:0] b);
    logic [DATA_W-1:0] value;
    reply_word_t       w;
    case (cmd_phase)
      PH_ADDR_LO: begin
        cmd_addr = {cmd_addr[ADDR_W-1:8], b};
        if (cmd_is_read) begin
          value = (cmd_addr < REG_COUNT) ? reg_mirror[cmd_addr[IDX_W-1:0]] : '0;
          for (int k = 0; k < 4; k++) begin
            w.tx_byte   = value[31 - 8 * k -: 8];
            w.last_byte = (k == 3);
            reply_q.push_back(w);
          end
          cmd_phase = PH_ADDR_HI;
        end else begin
          data_acc  = '0;
          cmd_phase = PH_DATA0;
        end
      end
      PH_DATA0, PH_DATA1, PH_DATA2: begin
        data_acc  = {data_acc[15:0], b};
        cmd_phase = cmd_phase + 3'd1;
      end
      PH_DATA3: begin
        // out-of-range writes are swallowed, no aliasing into the store
        if (cmd_addr < REG_COUNT) reg_mirror[cmd_addr[IDX_W-1:0]] = {data_acc, b};
        cmd_phase = PH_ADDR_HI;
      end
      default: begin
        cmd_is_read = b[7];
        cmd_addr    = {b[6:0], 8'h00};
        cmd_phase   = PH_ADDR_LO;
      end
    endcase
  endtask

  task automatic check_tx_word(input logic [7:0] got_byte, input logic got_last);
    reply_word_t w;
    if (reply_q.size() == 0) begin
      $error("tx word with no reply pending: tx_byte %h last_byte %b", got_byte, got_last);
      errors++;
    end else begin
      w = reply_q.pop_front();
      if (got_byte !== w.tx_byte) begin
        $error("tx_byte: expected %h, got %h", w.tx_byte, got_byte);
        errors++;
      end
      if (got_last !== w.last_byte) begin
        $error("last_byte: expected %b, got %b", w.last_byte, got_last);
        errors++;
      end
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_phase   = PH_ADDR_HI;
      cmd_addr    = '0;
      cmd_is_read = 1'b0;
      data_acc    = '0;
      for (int i = 0; i < REG_COUNT; i++) reg_mirror[i] = '0;
      reply_q.delete();
    end else begin
      if (rx.valid && rx.ready) take_rx_word(rx.rx_byte);
      if (tx.valid && tx.ready) check_tx_word(tx.tx_byte, tx.last_byte);
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the bridge testbench: clock, reset, rx command stimulus, tx backpressure.
// Depends on rbb_pkg, rbb_ifs, byte_stream_register_bridge and rbb_reply_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rbb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 96;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;
  int   words_sent;
  bit   rx_burst;
  bit   tx_burst;

  rbb_rx_if rx_ch();
  rbb_tx_if tx_ch();

  byte_stream_register_bridge u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch)
  );

  rbb_reply_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .tx      (tx_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // burst mode gives stretches with no idling at all
  function automatic int draw_idle(input bit burst);
    if (burst || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 17);
  endfunction

  task automatic send_word(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
    gap = draw_idle(rx_burst);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    send_word({1'b0, addr[14:8]});
    send_word(addr[7:0]);
    for (int k = 0; k < 4; k++) send_word(data[31 - 8 * k -: 8]);
  endtask

  task automatic send_read(input logic [ADDR_W-1:0] addr);
    send_word({1'b1, addr[14:8]});
    send_word(addr[7:0]);
  endtask

  // half the time one of four hot registers so reads land on written data
  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        case ($urandom_range(0, 3))
          0:       return 15'h0000;
          1:       return 15'h0001;
          2:       return 15'h007E;
          default: return 15'h00FF;
        endcase
      end
      5, 6, 7: return 15'($urandom_range(0, REG_COUNT - 1));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // tx backpressure: ready stays up until a word goes through
  initial begin
    int stall;
    tx_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
      stall = draw_idle(tx_burst);
      if (stall > 0) begin
        tx_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tx_ch.ready <= 1'b1;
      @(posedge clk);
      while (!tx_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int target;
    cycles = 0;
    words_sent = 0;
    rx_burst = 1'b0;
    tx_burst = 1'b0;
    rst <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: out-of-range write, aliasing and clear checks, data extremes
    send_write(15'h7FFF, 32'h5A5A_5A5A);
    send_read(15'h00FF);
    send_read(15'h7FFF);
    send_write(15'h00FF, 32'hFFFF_FFFF);
    send_read(15'h00FF);
    send_write(15'h0000, 32'h8000_0001);
    send_read(15'h0000);

    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          // stray words knock the framing around
          repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)));
        end
        2, 3, 4, 5, 6, 7, 8, 9, 10: send_write(pick_addr(), pick_data());
        default: send_read(pick_addr());
      endcase
    end

    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
